@@ rtl/bpc_pkg.sv @@
// Package for the button press classifier: event codes, configuration
// register indexes and the configuration bundle type.
// Depends on nothing; used by bpc_update and button_press_classifier.
`default_nettype none

package bpc_pkg;

    localparam int CFG_BITS = 16;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_BITS-1:0] SHORT_TICKS_RESET = 16'd5;
    localparam logic [CFG_BITS-1:0] LONG_TICKS_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0] WINDOW_TICKS_RESET = 16'd30;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SHORT_TICKS = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LONG_TICKS = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_TICKS = 2'd2;

    // Presses needed for a double press.
    localparam logic [2:0] DOUBLE_COUNT = 3'd2;

    typedef enum logic [1:0] {
        EV_IDLE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } press_event_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] short_ticks;
        logic [CFG_BITS-1:0] long_ticks;
        logic [CFG_BITS-1:0] window_ticks;
    } bpc_cfg_t;

endpackage

`default_nettype wire

@@ rtl/bpc_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Read data holds while no read is requested. Depends on nothing.
`default_nettype none

module bpc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  wire                                  clk,
    input  wire                                  we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                      wdata,
    input  wire                                  re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bpc_update.sv @@
// Per-button state update: advances the held and released timers of one
// entry and classifies the tick. Depends on bpc_pkg.
`default_nettype none

module bpc_update #(
    parameter int TIMER_BITS = 16
) (
    input  wire bpc_pkg::bpc_cfg_t         cfg,
    input  wire                            pressed,
    input  wire [2*TIMER_BITS+1:0]         cur_entry,
    output logic [2*TIMER_BITS+1:0]        next_entry,
    output bpc_pkg::press_event_t          press_event
);
    import bpc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] held;
    logic [TIMER_BITS-1:0] released;
    logic [1:0]            count;
    logic [TIMER_BITS-1:0] held_inc;
    logic [TIMER_BITS-1:0] released_inc;
    logic                  held_moved;
    logic                  released_moved;
    logic [2:0]            cnt;

    assign held     = cur_entry[TIMER_BITS-1:0];
    assign released = cur_entry[2*TIMER_BITS-1:TIMER_BITS];
    assign count    = cur_entry[2*TIMER_BITS+1:2*TIMER_BITS];

    assign held_moved     = (held != TIMER_MAX);
    assign released_moved = (released != TIMER_MAX);
    assign held_inc       = held_moved ? held + 1'b1 : held;
    assign released_inc   = released_moved ? released + 1'b1 : released;

    always_comb
    begin
        logic [TIMER_BITS-1:0] n_held;
        logic [TIMER_BITS-1:0] n_released;
        logic [1:0]            n_count;
        n_held      = held;
        n_released  = released;
        n_count     = count;
        press_event = EV_IDLE;
        cnt         = 3'({1'b0, count} + 3'd1);
        if (cnt > DOUBLE_COUNT)
        begin
            cnt = DOUBLE_COUNT;
        end
        if (pressed)
        begin
            n_held = held_inc;
            if (held_moved && CW'(held_inc) == CW'(cfg.short_ticks))
            begin
                press_event = EV_SHORT;
                n_count = cnt[1:0];
                if (cnt == DOUBLE_COUNT)
                begin
                    // The window is judged on the release time before this press.
                    if (CW'(released) <= CW'(cfg.window_ticks))
                    begin
                        press_event = EV_DOUBLE;
                    end
                    n_count = 2'd0;
                end
                n_released = '0;
            end
            else if (held_moved && CW'(held_inc) == CW'(cfg.long_ticks))
            begin
                press_event = EV_LONG;
                n_count = 2'd0;
            end
        end
        else
        begin
            n_released = released_inc;
            if (released_moved && CW'(released_inc) == CW'(cfg.window_ticks))
            begin
                n_count = 2'd0;
            end
            n_held = '0;
        end
        next_entry = {n_count, n_released, n_held};
    end

endmodule

`default_nettype wire

@@ rtl/button_press_classifier.sv @@
// Button press classifier: per-button short, long and double press detection.
// Each request on the slave stream is one tick sample of one button: tdata
// bit 0 is the button index and bit 1 the sampled level. For every request
// one result leaves on the master stream, tdata bits 1:0 carrying the event
// (idle, short, long or double press).
// The per-button timers and press count live in one RAM with a registered
// read. A request is read when it is accepted, then updated and written back
// from the update stage; the last write is forwarded, so samples of the same
// button may follow each other in consecutive cycles.
// A request passes the update stage register, then the output register, where
// its result waits to be taken; the block takes one request per cycle while
// results are taken.
// If the receiver stalls, the result waits in the output register; one more
// request may enter the update stage, after which tready falls until the
// result is taken.
// Reset clears the thresholds to 5, 100 and 30 ticks and marks every RAM
// entry as unwritten, which reads as zero state; there is no clearing pass.
// The user writes thresholds on the cfg port only while the stream is idle;
// the block does not enforce this. Depends on bpc_pkg, bpc_ram and bpc_update.
`default_nettype none

module button_press_classifier #(
    parameter int BUTTONS = 2,
    parameter int TIMER_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [bpc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire [bpc_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [7:0]                         s_tdata,   // [0] button_index, [1] pressed
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [7:0]                        m_tdata    // [1:0] press_event
);
    import bpc_pkg::*;

    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int EW = 2 * TIMER_BITS + 2;

    bpc_cfg_t       cfg_reg;
    logic           s1_valid_reg;
    logic [IW-1:0]  s1_addr_reg;
    logic           s1_pressed_reg;
    logic           s1_inrange_reg;
    logic           out_valid_reg;
    press_event_t   out_event_reg;
    logic           fwd_valid_reg;
    logic [IW-1:0]  fwd_addr_reg;
    logic [EW-1:0]  fwd_data_reg;
    logic [BUTTONS-1:0] valid_reg;

    logic           s_accept;
    logic           s1_adv;
    logic           in_range;
    logic [IW-1:0]  in_addr;
    logic           wr_en;
    logic [EW-1:0]  ram_rdata;
    logic [EW-1:0]  cur_entry;
    logic [EW-1:0]  next_entry;
    press_event_t   upd_event;
    press_event_t   event_next;
    logic           out_valid_next;

    assign in_addr  = IW'(s_tdata[0]);
    assign in_range = (32'(s_tdata[0]) < BUTTONS);

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s1_adv && s1_inrange_reg;

    bpc_ram #(
        .WIDTH(EW),
        .DEPTH(BUTTONS)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(s1_addr_reg),
        .wdata(next_entry),
        .re   (s_accept && in_range),
        .raddr(in_addr),
        .rdata(ram_rdata)
    );

    // The forwarding register always holds the latest write, so on an address
    // match it supersedes whatever the RAM returned.
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == s1_addr_reg)
        begin
            cur_entry = fwd_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            cur_entry = ram_rdata;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    bpc_update #(
        .TIMER_BITS(TIMER_BITS)
    ) u_update (
        .cfg        (cfg_reg),
        .pressed    (s1_pressed_reg),
        .cur_entry  (cur_entry),
        .next_entry (next_entry),
        .press_event(upd_event)
    );

    assign event_next     = s1_inrange_reg ? upd_event : EV_IDLE;
    assign out_valid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks  <= SHORT_TICKS_RESET;
            cfg_reg.long_ticks   <= LONG_TICKS_RESET;
            cfg_reg.window_ticks <= WINDOW_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SHORT_TICKS:  cfg_reg.short_ticks  <= cfg_wdata;
                CFG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_wdata;
                CFG_WINDOW_TICKS: cfg_reg.window_ticks <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                fwd_valid_reg          <= 1'b1;
                valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_addr_reg    <= in_addr;
            s1_pressed_reg <= s_tdata[1];
            s1_inrange_reg <= in_range;
        end
        if (s1_adv)
        begin
            out_event_reg <= event_next;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= next_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_event_reg};

endmodule

`default_nettype wire
